FILE: rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants of the priority thread scheduler: command codes, status
// codes, field widths and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // default sizes
  localparam int DefMaxThreads = 8;
  localparam int DefSemaphores = 8;

  // field widths
  localparam int CmdW    = 3;
  localparam int PrioW   = 8;
  localparam int SleepW  = 32;
  localparam int SemIdW  = 3;
  localparam int SlotOW  = 3;
  localparam int StatW   = 3;
  localparam int ActOW   = 4;
  localparam int SemCntW = 16;

  // command codes
  localparam logic [CmdW-1:0] CmdTick   = 3'd0;
  localparam logic [CmdW-1:0] CmdSched  = 3'd1;
  localparam logic [CmdW-1:0] CmdCreate = 3'd2;
  localparam logic [CmdW-1:0] CmdKill   = 3'd3;
  localparam logic [CmdW-1:0] CmdSleep  = 3'd4;
  localparam logic [CmdW-1:0] CmdWait   = 3'd5;
  localparam logic [CmdW-1:0] CmdSignal = 3'd6;

  // status codes
  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StFull     = 3'd1;
  localparam logic [StatW-1:0] StLastKill = 3'd2;
  localparam logic [StatW-1:0] StNoWaiter = 3'd3;
  localparam logic [StatW-1:0] StNoThread = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/pts_cmd_if.sv
// ----------------------------------------------------------------------------
// pts_cmd_if
// Command channel: valid/ready handshake with one scheduler command.
// ----------------------------------------------------------------------------
`default_nettype none

interface pts_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::CmdW-1:0]      command;
  logic [pts_pkg::PrioW-1:0]     priority_req;
  logic [pts_pkg::SleepW-1:0]    sleep_ms;
  logic [pts_pkg::SemIdW-1:0]    sem_id;

  modport source (output valid, command, priority_req, sleep_ms, sem_id, input ready);
  modport sink   (input valid, command, priority_req, sleep_ms, sem_id, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pts_res_if.sv
// ----------------------------------------------------------------------------
// pts_res_if
// Result channel: valid/ready handshake with one scheduler result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pts_res_if;
  logic                         valid;
  logic                         ready;
  logic [pts_pkg::SlotOW-1:0]   running_slot;
  logic [pts_pkg::SlotOW-1:0]   created_slot;
  logic [pts_pkg::StatW-1:0]    status;
  logic                         running_blocked;
  logic [pts_pkg::ActOW-1:0]    active_count;

  modport source (output valid, running_slot, created_slot, status, running_blocked,
                  active_count, input ready);
  modport sink   (input valid, running_slot, created_slot, status, running_blocked,
                  active_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/priority_thread_scheduler_core.sv
// Sequence: a tick sweeps every slot; schedule and kill walk the slot ring, and
//   signal may, visiting at most MAX_THREADS slots; other commands do not walk.
// Throughput: one command at a time, set by the walk over the slot RAM, which
//   has one read and one write port; the result register frees the input side.
// Reset: all slots free, no sleeps or blocks, semaphore counts zero, through
//   per-entry valid bits; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// priority_thread_scheduler_core
// Thread-slot scheduler: slot records and semaphore counts live in RAMs,
// a sequencer reads, modifies and writes them back per command.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_thread_scheduler_core #(
  parameter int MAX_THREADS = pts_pkg::DefMaxThreads,
  parameter int SEMAPHORES  = pts_pkg::DefSemaphores
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pts_cmd_if.sink    cmd_i,
  pts_res_if.source  res_o
);

  localparam int SlotW = $clog2(MAX_THREADS);
  localparam int CntW  = $clog2(MAX_THREADS + 1);
  localparam int SemAw = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam int SlpLo = SlotW;
  localparam int BlkB  = SlotW + pts_pkg::SleepW;
  localparam int BsmLo = BlkB + 1;
  localparam int PriLo = BsmLo + pts_pkg::SemIdW;
  localparam int RecW  = PriLo + pts_pkg::PrioW;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TICK_RA  = 4'd1;
  localparam logic [3:0] S_TICK_DAT = 4'd2;
  localparam logic [3:0] S_CUR_RA   = 4'd3;
  localparam logic [3:0] S_CUR_DAT  = 4'd4;
  localparam logic [3:0] S_CRT_NEW  = 4'd5;
  localparam logic [3:0] S_CRT_WR2  = 4'd6;
  localparam logic [3:0] S_SCH_DAT  = 4'd7;
  localparam logic [3:0] S_KIL_DAT  = 4'd8;
  localparam logic [3:0] S_SIG_DAT  = 4'd9;
  localparam logic [3:0] S_FIN_RA   = 4'd10;
  localparam logic [3:0] S_FIN_DAT  = 4'd11;

  function automatic logic [RecW-1:0] rec_pack(
    input logic [pts_pkg::PrioW-1:0]  p,
    input logic [pts_pkg::SemIdW-1:0] bs,
    input logic                       b,
    input logic [pts_pkg::SleepW-1:0] s,
    input logic [SlotW-1:0]           sc
  );
    return {p, bs, b, s, sc};
  endfunction

  logic [3:0]                    state_q, state_d;
  logic [SlotW-1:0]              cur_q, cur_d;
  logic [CntW-1:0]               active_q, active_d;
  logic [MAX_THREADS-1:0]        in_use_q, in_use_d;
  logic [MAX_THREADS-1:0]        rec_vld_q, rec_vld_d;
  logic [SEMAPHORES-1:0]         sem_vld_q, sem_vld_d;
  logic                          out_vld_q, out_vld_d;

  logic [pts_pkg::CmdW-1:0]      cmd_q, cmd_d;
  logic [pts_pkg::PrioW-1:0]     prio_q, prio_d;
  logic [pts_pkg::SleepW-1:0]    slp_q, slp_d;
  logic [pts_pkg::SemIdW-1:0]    sem_q, sem_d;
  logic [SlotW-1:0]              idx_q, idx_d;
  logic [CntW-1:0]               n_q, n_d;
  logic [SlotW-1:0]              it_q, it_d;
  logic [SlotW-1:0]              start_q, start_d;
  logic [SlotW-1:0]              best_q, best_d;
  logic [pts_pkg::PrioW-1:0]     maxp_q, maxp_d;
  logic [SlotW-1:0]              prev_q, prev_d;
  logic [SlotW-1:0]              csucc_q, csucc_d;
  logic [RecW-1:0]               cur_rec_q, cur_rec_d;
  logic [pts_pkg::StatW-1:0]     status_q, status_d;
  logic [SlotW-1:0]              created_q, created_d;
  logic                          rvld_q, svld_q;

  logic [pts_pkg::SlotOW-1:0]    res_run_q, res_crt_q;
  logic [pts_pkg::StatW-1:0]     res_st_q;
  logic                          res_blk_q;
  logic [pts_pkg::ActOW-1:0]     res_act_q;
  logic                          out_load;

  // ram ports
  logic                          rec_we;
  logic [SlotW-1:0]              rec_waddr, rec_raddr;
  logic [RecW-1:0]               rec_wdata, rec_rdata, rec_rd;
  logic                          sem_we;
  logic [SemAw-1:0]              sem_addr;
  logic [pts_pkg::SemCntW-1:0]   sem_wdata, sem_rdata;
  logic signed [pts_pkg::SemCntW-1:0] sem_rd, sem_dec, sem_inc;

  // decoded record fields
  logic [SlotW-1:0]              r_succ;
  logic [pts_pkg::SleepW-1:0]    r_sleep;
  logic                          r_blk;
  logic [pts_pkg::SemIdW-1:0]    r_bsem;
  logic [pts_pkg::PrioW-1:0]     r_prio;

  logic [SlotW-1:0]              free_idx;
  logic                          live, sem_in_range, take;
  logic [CntW-1:0]               n_inc;

  pts_ram #(.Width(RecW), .Depth(MAX_THREADS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  pts_ram #(.Width(pts_pkg::SemCntW), .Depth(SEMAPHORES)) u_sem_ram (
    .clk_i   (clk_i),
    .we_i    (sem_we),
    .waddr_i (sem_addr),
    .wdata_i (sem_wdata),
    .raddr_i (sem_addr),
    .rdata_o (sem_rdata)
  );

  // unwritten entries read as their reset value
  assign rec_rd  = rvld_q ? rec_rdata : '0;
  assign sem_rd  = svld_q ? sem_rdata : '0;
  assign r_succ  = rec_rd[SlotW-1:0];
  assign r_sleep = rec_rd[SlpLo +: pts_pkg::SleepW];
  assign r_blk   = rec_rd[BlkB];
  assign r_bsem  = rec_rd[BsmLo +: pts_pkg::SemIdW];
  assign r_prio  = rec_rd[PriLo +: pts_pkg::PrioW];

  assign sem_addr = SemAw'(sem_q);
  assign sem_dec  = (sem_rd == 16'sh8000) ? sem_rd : sem_rd - 16'sd1;
  assign sem_inc  = (sem_rd == 16'sh7fff) ? sem_rd : sem_rd + 16'sd1;

  assign live         = (active_q != '0) && in_use_q[cur_q];
  assign sem_in_range = 32'(cmd_i.sem_id) < SEMAPHORES;
  assign take         = (r_prio > maxp_q) && (r_sleep == '0) && !r_blk;
  assign n_inc        = n_q + CntW'(1);

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  // command sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    active_d  = active_q;
    in_use_d  = in_use_q;
    rec_vld_d = rec_vld_q;
    sem_vld_d = sem_vld_q;
    cmd_d     = cmd_q;
    prio_d    = prio_q;
    slp_d     = slp_q;
    sem_d     = sem_q;
    idx_d     = idx_q;
    n_d       = n_q;
    it_d      = it_q;
    start_d   = start_q;
    best_d    = best_q;
    maxp_d    = maxp_q;
    prev_d    = prev_q;
    csucc_d   = csucc_q;
    cur_rec_d = cur_rec_q;
    status_d  = status_q;
    created_d = created_q;
    rec_raddr = cur_q;
    rec_we    = 1'b0;
    rec_waddr = cur_q;
    rec_wdata = cur_rec_q;
    sem_we    = 1'b0;
    sem_wdata = sem_rd;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d     = cmd_i.command;
          prio_d    = cmd_i.priority_req;
          slp_d     = cmd_i.sleep_ms;
          sem_d     = cmd_i.sem_id;
          status_d  = pts_pkg::StOk;
          created_d = '0;
          n_d       = '0;
          idx_d     = '0;
          state_d   = S_FIN_RA;
          case (cmd_i.command)
            pts_pkg::CmdTick: begin
              state_d = S_TICK_RA;
            end
            pts_pkg::CmdSched: begin
              if (active_q == '0) status_d = pts_pkg::StNoThread;
              else state_d = S_CUR_RA;
            end
            pts_pkg::CmdCreate: begin
              if (active_q == CntW'(MAX_THREADS)) status_d = pts_pkg::StFull;
              else if (active_q != '0 && !in_use_q[cur_q]) status_d = pts_pkg::StNoThread;
              else if (active_q == '0) state_d = S_CRT_NEW;
              else state_d = S_CUR_RA;
            end
            pts_pkg::CmdKill: begin
              if (!live) status_d = pts_pkg::StNoThread;
              else if (active_q == CntW'(1)) status_d = pts_pkg::StLastKill;
              else state_d = S_CUR_RA;
            end
            pts_pkg::CmdSleep: begin
              if (!live) status_d = pts_pkg::StNoThread;
              else state_d = S_CUR_RA;
            end
            pts_pkg::CmdWait: begin
              if (!sem_in_range) state_d = S_FIN_RA;
              else if (!live) status_d = pts_pkg::StNoThread;
              else state_d = S_CUR_RA;
            end
            pts_pkg::CmdSignal: begin
              if (sem_in_range) state_d = S_CUR_RA;
            end
            default: begin
              state_d = S_FIN_RA;
            end
          endcase
        end
      end

      // sleep countdown sweep over all slots
      S_TICK_RA: begin
        rec_raddr = idx_q;
        state_d   = S_TICK_DAT;
      end
      S_TICK_DAT: begin
        if (r_sleep != '0) begin
          rec_we    = 1'b1;
          rec_waddr = idx_q;
          rec_wdata = rec_pack(r_prio, r_bsem, r_blk, r_sleep - 32'd1, r_succ);
        end
        if (idx_q == SlotW'(MAX_THREADS - 1)) begin
          state_d = S_FIN_RA;
        end else begin
          idx_d   = idx_q + SlotW'(1);
          state_d = S_TICK_RA;
        end
      end

      // first thread links to itself
      S_CRT_NEW: begin
        rec_we              = 1'b1;
        rec_waddr           = free_idx;
        rec_wdata           = rec_pack(prio_q, '0, 1'b0, '0, free_idx);
        rec_vld_d[free_idx] = 1'b1;
        in_use_d[free_idx]  = 1'b1;
        active_d            = active_q + CntW'(1);
        cur_d               = free_idx;
        created_d           = free_idx;
        state_d             = S_FIN_RA;
      end

      S_CUR_RA: begin
        state_d = S_CUR_DAT;
      end

      // record of the running slot is here
      S_CUR_DAT: begin
        cur_rec_d = rec_rd;
        state_d   = S_FIN_RA;
        case (cmd_q)
          pts_pkg::CmdSched: begin
            start_d   = r_succ;
            it_d      = r_succ;
            best_d    = r_succ;
            maxp_d    = r_prio;
            rec_raddr = r_succ;
            state_d   = S_SCH_DAT;
          end
          pts_pkg::CmdCreate: begin
            rec_we              = 1'b1;
            rec_waddr           = free_idx;
            rec_wdata           = rec_pack(prio_q, '0, 1'b0, '0, r_succ);
            rec_vld_d[free_idx] = 1'b1;
            in_use_d[free_idx]  = 1'b1;
            active_d            = active_q + CntW'(1);
            created_d           = free_idx;
            state_d             = S_CRT_WR2;
          end
          pts_pkg::CmdKill: begin
            csucc_d   = r_succ;
            prev_d    = r_succ;
            rec_raddr = r_succ;
            state_d   = S_KIL_DAT;
          end
          pts_pkg::CmdSleep: begin
            rec_we    = 1'b1;
            rec_wdata = rec_pack(r_prio, r_bsem, r_blk, slp_q, r_succ);
          end
          pts_pkg::CmdWait: begin
            sem_we              = 1'b1;
            sem_wdata           = sem_dec;
            sem_vld_d[sem_addr] = 1'b1;
            if (sem_dec[pts_pkg::SemCntW-1]) begin
              rec_we    = 1'b1;
              rec_wdata = rec_pack(r_prio, sem_q, 1'b1, r_sleep, r_succ);
            end
          end
          pts_pkg::CmdSignal: begin
            sem_we              = 1'b1;
            sem_wdata           = sem_inc;
            sem_vld_d[sem_addr] = 1'b1;
            if (!sem_inc[pts_pkg::SemCntW-1] && sem_inc != '0) begin
              state_d = S_FIN_RA;
            end else if (active_q == '0) begin
              status_d = pts_pkg::StNoWaiter;
            end else begin
              start_d   = r_succ;
              it_d      = r_succ;
              rec_raddr = r_succ;
              state_d   = S_SIG_DAT;
            end
          end
          default: begin
            state_d = S_FIN_RA;
          end
        endcase
      end

      // link the new slot behind the running one
      S_CRT_WR2: begin
        rec_we    = 1'b1;
        rec_wdata = {cur_rec_q[RecW-1:SlotW], created_q};
        state_d   = S_FIN_RA;
      end

      // ring walk for the highest ready priority
      S_SCH_DAT: begin
        if (take) begin
          best_d = it_q;
          maxp_d = r_prio;
        end
        if (r_succ == start_q || n_inc == CntW'(MAX_THREADS)) begin
          cur_d   = take ? it_q : best_q;
          state_d = S_FIN_RA;
        end else begin
          it_d      = r_succ;
          n_d       = n_inc;
          rec_raddr = r_succ;
        end
      end

      // ring walk for the predecessor of the running slot
      S_KIL_DAT: begin
        if (r_succ == cur_q || n_inc == CntW'(MAX_THREADS)) begin
          rec_we          = 1'b1;
          rec_waddr       = prev_q;
          rec_wdata       = {rec_rd[RecW-1:SlotW], csucc_q};
          in_use_d[cur_q] = 1'b0;
          active_d        = active_q - CntW'(1);
          state_d         = S_FIN_RA;
        end else begin
          prev_d    = r_succ;
          n_d       = n_inc;
          rec_raddr = r_succ;
        end
      end

      // ring walk for a waiter on the semaphore
      S_SIG_DAT: begin
        if (in_use_q[it_q] && r_blk && r_bsem == sem_q) begin
          rec_we    = 1'b1;
          rec_waddr = it_q;
          rec_wdata = rec_pack(r_prio, r_bsem, 1'b0, r_sleep, r_succ);
          state_d   = S_FIN_RA;
        end else if (r_succ == start_q || n_inc == CntW'(MAX_THREADS)) begin
          status_d = pts_pkg::StNoWaiter;
          state_d  = S_FIN_RA;
        end else begin
          it_d      = r_succ;
          n_d       = n_inc;
          rec_raddr = r_succ;
        end
      end

      // read the running slot for the blocked flag
      S_FIN_RA: begin
        state_d = S_FIN_DAT;
      end
      S_FIN_DAT: begin
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) out_vld_d = 1'b1;
    else if (res_o.ready) out_vld_d = 1'b0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '0;
      active_q  <= '0;
      in_use_q  <= '0;
      rec_vld_q <= '0;
      sem_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      active_q  <= active_d;
      in_use_q  <= in_use_d;
      rec_vld_q <= rec_vld_d;
      sem_vld_q <= sem_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    prio_q    <= prio_d;
    slp_q     <= slp_d;
    sem_q     <= sem_d;
    idx_q     <= idx_d;
    n_q       <= n_d;
    it_q      <= it_d;
    start_q   <= start_d;
    best_q    <= best_d;
    maxp_q    <= maxp_d;
    prev_q    <= prev_d;
    csucc_q   <= csucc_d;
    cur_rec_q <= cur_rec_d;
    status_q  <= status_d;
    created_q <= created_d;
    rvld_q    <= rec_vld_q[rec_raddr];
    svld_q    <= sem_vld_q[sem_addr];
    if (out_load) begin
      res_run_q <= pts_pkg::SlotOW'(cur_q);
      res_crt_q <= pts_pkg::SlotOW'(created_q);
      res_st_q  <= status_q;
      res_blk_q <= in_use_q[cur_q] && r_blk;
      res_act_q <= pts_pkg::ActOW'(active_q);
    end
  end

  assign cmd_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = out_vld_q;
  assign res_o.running_slot    = res_run_q;
  assign res_o.created_slot    = res_crt_q;
  assign res_o.status          = res_st_q;
  assign res_o.running_blocked = res_blk_q;
  assign res_o.active_count    = res_act_q;

endmodule

`default_nettype wire
